@@ hw/rtl/button_mic_debounce_click_longpress_defines.svh @@
// Assertion macros for the button and microphone front end.
// Included by the top level; relies on clk and arst_n in the including scope.
`ifndef BUTTON_MIC_DEBOUNCE_CLICK_LONGPRESS_DEFINES_SVH
`define BUTTON_MIC_DEBOUNCE_CLICK_LONGPRESS_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BMDC_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BMDC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

@@ hw/rtl/bmdc_pkg.sv @@
// Shared types and constants for the button and microphone front end.
// No dependencies; used by bmdc_step and the top level.
package bmdc_pkg;

	// Configuration register indexes
	localparam logic [1:0] REG_DEBOUNCE_TICKS     = 2'd0;
	localparam logic [1:0] REG_CLICK_WINDOW_TICKS = 2'd1;
	localparam logic [1:0] REG_LONG_PRESS_TICKS   = 2'd2;
	localparam logic [1:0] REG_STATUS_CLICK_COUNT = 2'd3;

	// Configuration reset values
	localparam logic [3:0] DEBOUNCE_TICKS_RST     = 4'd2;
	localparam logic [7:0] CLICK_WINDOW_TICKS_RST = 8'd50;
	localparam logic [7:0] LONG_PRESS_TICKS_RST   = 8'd150;
	localparam logic [3:0] STATUS_CLICK_COUNT_RST = 4'd3;

	// Activity flag bits
	localparam int ACT_ARMED  = 0;
	localparam int ACT_KEYSMK = 1;
	localparam int ACT_MICSMK = 2;
	localparam int ACT_MODE   = 3;

	// Accepted level bits
	localparam int LVL_MIC = 0;
	localparam int LVL_KEY = 1;

	localparam logic [1:0] GEAR_FIRST = 2'd0;
	localparam logic [1:0] GEAR_LAST  = 2'd2;

	typedef struct packed {
		logic [3:0] debounce_ticks;
		logic [7:0] click_window_ticks;
		logic [7:0] long_press_ticks;
		logic [3:0] status_click_count;
	} cfg_t;

	typedef struct packed {
		logic       output_firing;
		logic       mic_down;
		logic       key_down;
	} item_t;

	typedef struct packed {
		logic       sleep_reset;
		logic       status_request;
		logic       smoke_stop;
		logic       smoke_start;
		logic       power_toggled;
		logic       powered_off;
		logic       gear_changed;
		logic [1:0] gear_level;
	} result_t;

	typedef struct packed {
		logic [1:0] accepted_levels;
		logic [3:0] change_count;
		logic [7:0] click_count;
		logic [7:0] window_timer;
		logic [7:0] hold_timer;
		logic [3:0] activity_flags;
		logic [1:0] gear_state;
		logic       off_flag;
	} state_t;

endpackage

@@ hw/rtl/bmdc_step.sv @@
// One tick of debounce, click counting, long-press timing and gear stepping.
// Pure combinational next-state and result logic; depends on bmdc_pkg.
module bmdc_step (
	input  bmdc_pkg::cfg_t    cfg,
	input  bmdc_pkg::state_t  cur,
	input  bmdc_pkg::item_t   item,
	output bmdc_pkg::state_t  nxt,
	output bmdc_pkg::result_t res
);
	import bmdc_pkg::*;

	logic [1:0] sample;
	logic [3:0] cnt_inc;
	logic       firing;
	logic [1:0] old_lvl;

	always_comb begin
		sample  = {item.key_down, item.mic_down};
		firing  = item.output_firing;
		cnt_inc = cur.change_count + 4'd1;
		old_lvl = cur.accepted_levels;
		nxt     = cur;
		res     = '0;

		// Debounce: any differing sample counts toward acceptance
		if (sample != old_lvl) begin
			nxt.change_count = cnt_inc;
			if (cnt_inc >= cfg.debounce_ticks) begin
				if (!old_lvl[LVL_KEY] && sample[LVL_KEY]) begin
					nxt.click_count                = cur.click_count + 8'd1;
					nxt.window_timer               = cfg.click_window_ticks;
					nxt.activity_flags[ACT_ARMED]  = 1'b1;
					nxt.hold_timer                 = '0;
					nxt.gear_state = (cur.gear_state >= GEAR_LAST) ? GEAR_FIRST
						: cur.gear_state + 2'd1;
					res.gear_changed = 1'b1;
				end else if (old_lvl[LVL_KEY] && !sample[LVL_KEY]) begin
					nxt.activity_flags[ACT_ARMED] = 1'b0;
				end
				if (!old_lvl[LVL_MIC] && sample[LVL_MIC]) begin
					if (!nxt.activity_flags[ACT_KEYSMK]) begin
						nxt.activity_flags[ACT_MICSMK] = 1'b1;
						nxt.activity_flags[ACT_MODE]   = 1'b0;
						res.smoke_start = 1'b1;
					end
				end else if (old_lvl[LVL_MIC] && !sample[LVL_MIC]) begin
					if (nxt.activity_flags[ACT_MICSMK]) begin
						if (firing) begin
							nxt.activity_flags[ACT_KEYSMK] = 1'b0;
							nxt.activity_flags[ACT_MODE]   = 1'b0;
						end
						nxt.activity_flags[ACT_MICSMK] = 1'b0;
						res.smoke_stop = 1'b1;
					end
				end
				res.sleep_reset      = 1'b1;
				nxt.change_count     = '0;
				nxt.accepted_levels  = sample;
			end
		end else begin
			nxt.change_count = '0;
		end

		// Click window countdown; a press loaded this tick still counts down
		if (nxt.window_timer != 8'd0) begin
			nxt.window_timer = nxt.window_timer - 8'd1;
		end else begin
			if (!nxt.activity_flags[ACT_ARMED] && !nxt.activity_flags[ACT_KEYSMK] &&
				!nxt.activity_flags[ACT_MICSMK] && !cur.off_flag && !firing &&
				nxt.click_count == {4'd0, cfg.status_click_count})
				res.status_request = 1'b1;
			nxt.click_count = '0;
		end

		// Long press: count while held, toggle power when reached
		if (nxt.activity_flags[ACT_ARMED]) begin
			if (nxt.hold_timer < cfg.long_press_ticks) begin
				nxt.hold_timer  = nxt.hold_timer + 8'd1;
				res.sleep_reset = 1'b1;
			end else begin
				nxt.activity_flags[ACT_ARMED] = 1'b0;
				nxt.click_count               = '0;
				if (firing) begin
					nxt.activity_flags[ACT_KEYSMK] = 1'b0;
					nxt.activity_flags[ACT_MICSMK] = 1'b0;
					nxt.activity_flags[ACT_MODE]   = 1'b0;
				end
				res.smoke_stop    = 1'b1;
				nxt.off_flag      = ~cur.off_flag;
				res.power_toggled = 1'b1;
			end
		end

		if (nxt.click_count != 8'd0 || item.mic_down)
			res.sleep_reset = 1'b1;

		res.gear_level  = nxt.gear_state;
		res.powered_off = nxt.off_flag;
	end

endmodule

@@ hw/rtl/button_mic_debounce_click_longpress.sv @@
// Key and microphone front end: one request on the slave stream is one scan tick
// (key level, mic level, firing flag) and yields exactly one result request on
// the master stream. Throughput is one tick per clock while the master side
// takes results. Input and result registers sit around the single-pass step
// logic. Both stages advance whenever the result register is empty or being
// taken, so a stalled master side holds at most two ticks in flight.
// Configuration writes take effect at the next clock edge and are meant to be
// made while no tick is in flight. Depends on bmdc_pkg and bmdc_step.
`include "button_mic_debounce_click_longpress_defines.svh"
module button_mic_debounce_click_longpress (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // key_down, mic_down, output_firing, zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // gear_level[1:0], gear_changed, powered_off,
	                               // power_toggled, smoke_start, smoke_stop,
	                               // status_request, sleep_reset, zero pad
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import bmdc_pkg::*;

	cfg_t    cfg_q;
	state_t  state_q;
	state_t  state_nxt;
	item_t   item_s1;
	logic    valid_s1;
	result_t res_s2;
	result_t res_nxt;
	logic    valid_s2;
	logic    load_s2;

	// Result stage takes a new request when empty or when drained this cycle
	assign load_s2  = valid_s1 && (!valid_s2 || m_tready);
	assign s_tready = !valid_s1 || load_s2;
	assign m_tvalid = valid_s2;
	assign m_tdata  = {7'd0, res_s2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ticks     <= DEBOUNCE_TICKS_RST;
			cfg_q.click_window_ticks <= CLICK_WINDOW_TICKS_RST;
			cfg_q.long_press_ticks   <= LONG_PRESS_TICKS_RST;
			cfg_q.status_click_count <= STATUS_CLICK_COUNT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE_TICKS:     cfg_q.debounce_ticks     <= cfg_data[3:0];
				REG_CLICK_WINDOW_TICKS: cfg_q.click_window_ticks <= cfg_data;
				REG_LONG_PRESS_TICKS:   cfg_q.long_press_ticks   <= cfg_data;
				REG_STATUS_CLICK_COUNT: cfg_q.status_click_count <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			state_q  <= '0;
		end else begin
			if (s_tready)
				valid_s1 <= s_tvalid;
			if (load_s2) begin
				valid_s2 <= 1'b1;
				state_q  <= state_nxt;
			end else if (m_tready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid)
			item_s1 <= s_tdata[2:0];
		if (load_s2)
			res_s2 <= res_nxt;
	end

	bmdc_step u_step (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	`BMDC_ASSERT_SAME(a_gear_range, 1'b1, state_q.gear_state != 2'd3, "gear reached code three")
	`BMDC_ASSERT_NEXT(a_power_toggle, load_s2 && res_nxt.power_toggled, state_q.off_flag != $past(state_q.off_flag), "power toggle without off flag change")
	`BMDC_ASSERT_SAME(a_accept_sleep, load_s2 && state_nxt.accepted_levels != state_q.accepted_levels, res_nxt.sleep_reset, "accepted change without sleep reset")
	`BMDC_ASSERT_SAME(a_stall_full, !s_tready, valid_s1 && valid_s2, "input stalled with free stage")

endmodule
